// ===== hdl/arw_pkg.sv =====
// Shared types and constants for the anti-replay window block.
// No dependencies; imported by arw_bitmap and anti_replay_window.
`default_nettype none

package arw_pkg;

  localparam int SEQ_W      = 32;
  localparam int LOG2_W     = 4;
  localparam int MIN_LOG2   = 3;
  localparam logic [LOG2_W-1:0] RESET_LOG2 = 4'd8;
  localparam int OUT_DATA_W = 8;

  // Bitmap update command for one item
  typedef struct packed {
    logic apply;        // commit an update this cycle
    logic clear_all;    // clear every slot of the active window
    logic clear_range;  // clear the slots overtaken by a forward move
    logic mark;         // set the slot of the current number
  } arw_upd_t;

endpackage : arw_pkg

`default_nettype wire

// ===== hdl/arw_bitmap.sv =====
// Replay window bitmap: one flop per slot, read at one slot, range clear.
// Depends on arw_pkg (arw_upd_t).
`default_nettype none

module arw_bitmap
  import arw_pkg::*;
#(
  parameter int MAX_WINDOW = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [$clog2(MAX_WINDOW)-1:0] slot,
  input  wire logic [$clog2(MAX_WINDOW)-1:0] wmask,
  input  wire logic [$clog2(MAX_WINDOW)-1:0] top_low,
  input  wire logic [$clog2(MAX_WINDOW)-1:0] span,
  input  wire arw_upd_t                      ctl,
  output logic                               seen
);

  localparam int IDX_W = $clog2(MAX_WINDOW);

  logic [MAX_WINDOW-1:0] bits;
  logic [MAX_WINDOW-1:0] bits_next;

  assign seen = bits[slot];

  // Slot j is overtaken when its distance ahead of top, mod W, is in 1..span
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      logic [IDX_W-1:0] jj;
      logic [IDX_W-1:0] off;
      logic             in_win;
      logic             clr;
      jj        = IDX_W'(j);
      off       = (jj - top_low) & wmask;
      in_win    = (jj & ~wmask) == '0;
      clr       = in_win && (ctl.clear_all ||
                  (ctl.clear_range && (off != '0) && (off <= span)));
      bits_next[j] = bits[j];
      if (ctl.apply) begin
        if (ctl.mark && (jj == slot)) begin
          bits_next[j] = 1'b1;
        end else if (clr) begin
          bits_next[j] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else begin
      bits <= bits_next;
    end
  end

endmodule : arw_bitmap

`default_nettype wire

// ===== hdl/anti_replay_window.sv =====
// Sliding-window anti-replay check, top level.
// Depends on arw_pkg and arw_bitmap.
//
//   channel  dir  signals                       payload
//   s_*      in   s_tvalid/s_tready/s_tdata     seq [31:0]
//   m_*      out  m_tvalid/m_tready/m_tdata     accept [0], zero pad [7:1]
//   cfg_*    in   cfg_valid/cfg_ready/cfg_data  window_log2 [3:0]
//
// One item per clock sustained while m_tready is high. An item waits in the
// input register, where the decision and the bitmap/top update happen in a
// single pass; the result is then registered in the output register, or in
// the skid register when the output is held. The skid register behind the
// output lets one more result in while m_tready is low; s_tready drops only
// when the skid and the input register are both full.
// Reset (rst, sync, active high) empties the pipe, clears the bitmap and
// top, and sets window_log2 to 8. cfg_ready is always high.
`default_nettype none

module anti_replay_window
  import arw_pkg::*;
#(
  parameter int MAX_WINDOW = 256   // power of two, 8..4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input items
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SEQ_W-1:0]      s_tdata,   // [31:0] seq
  // result items
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [0] accept, [7:1] zero
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [LOG2_W-1:0]     cfg_data   // [3:0] window_log2
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam logic [LOG2_W-1:0] MAX_LOG2 = LOG2_W'(IDX_W);
  localparam logic [LOG2_W-1:0] LO_LOG2  = LOG2_W'(MIN_LOG2);

  // Configuration register
  logic [LOG2_W-1:0] window_log2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_log2 <= RESET_LOG2;
    end else if (cfg_valid && cfg_ready) begin
      window_log2 <= cfg_data;
    end
  end

  // Effective width: log2 saturated to MIN_LOG2..log2(MAX_WINDOW)
  logic [LOG2_W-1:0] lg_eff;
  logic [IDX_W:0]    w_one;
  logic [IDX_W:0]    w_m1;
  logic [IDX_W-1:0]  wmask;
  logic [SEQ_W-1:0]  w32;

  always_comb begin
    if (window_log2 < LO_LOG2) begin
      lg_eff = LO_LOG2;
    end else if (window_log2 > MAX_LOG2) begin
      lg_eff = MAX_LOG2;
    end else begin
      lg_eff = window_log2;
    end
    w_one = {{IDX_W{1'b0}}, 1'b1} << lg_eff;
    w_m1  = w_one - 1'b1;
    wmask = w_m1[IDX_W-1:0];
    w32   = SEQ_W'(w_one);
  end

  // Input register
  logic             in_valid;
  logic [SEQ_W-1:0] in_seq;
  logic             advance;

  // Output register plus skid
  logic out_valid;
  logic out_acc;
  logic skid_valid;
  logic skid_acc;
  logic pop;

  assign advance  = in_valid && !skid_valid;
  assign s_tready = !in_valid || !skid_valid;
  assign pop      = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_seq <= s_tdata;
    end
  end

  // Window state
  logic             started;
  logic [SEQ_W-1:0] top_seq;

  // Decision for the item in the input register
  logic [SEQ_W-1:0] d;
  logic [SEQ_W-1:0] nd;
  logic             behind;
  logic             ahead;
  logic             too_old;
  logic             far_ahead;
  logic             seen;
  logic [IDX_W-1:0] slot;
  logic             acc;
  arw_upd_t         upd;

  assign d    = in_seq - top_seq;
  assign nd   = top_seq - in_seq;
  assign slot = in_seq[IDX_W-1:0] & wmask;

  always_comb begin
    behind    = d[SEQ_W-1];
    ahead     = !behind && (d != '0);
    too_old   = behind && (nd >= w32);   // covers the -2^31 corner too
    far_ahead = ahead && (d >= w32);
    upd       = '0;
    acc       = 1'b0;
    if (!started) begin
      // first item: fresh window around it
      acc           = 1'b1;
      upd.clear_all = 1'b1;
      upd.mark      = 1'b1;
    end else if (ahead) begin
      acc             = 1'b1;
      upd.clear_all   = far_ahead;
      upd.clear_range = !far_ahead;
      upd.mark        = 1'b1;
    end else if (!too_old && !seen) begin
      acc      = 1'b1;
      upd.mark = 1'b1;
    end
    upd.apply = advance && acc;
  end

  arw_bitmap #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .slot    (slot),
    .wmask   (wmask),
    .top_low (top_seq[IDX_W-1:0]),
    .span    (d[IDX_W-1:0]),
    .ctl     (upd),
    .seen    (seen)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      top_seq <= '0;
    end else if (advance && (!started || ahead)) begin
      started <= 1'b1;
      top_seq <= in_seq;
    end
  end

  // Result path
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (advance) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!out_valid || pop) begin
        out_acc <= acc;
      end else begin
        skid_acc <= acc;
      end
    end else if (pop && skid_valid) begin
      out_acc <= skid_acc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_acc};

endmodule : anti_replay_window

`default_nettype wire
